>>> sv/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Expects a clock named clk and an active-low reset named arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted
`define ASSERT_AT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	`ASSERT_AT_CLK(label, (ante) |-> (cons), msg)

`endif

>>> sv/rmq_pkg.sv
// Package for the rotation matrix to quaternion unit: widths, codes,
// transaction structs and pipeline side-band types. Depends on nothing.
package rmq_pkg;

	localparam int DW = 32;          // data word width
	localparam int FB = DW - 2;      // fraction bits of Q1.(DW-2)
	localparam int TW = DW + 2;      // trace width
	localparam int AW = DW + 4;      // square-root argument width
	localparam int NW = DW + 1;      // off-diagonal sum width
	localparam int RW = DW + 3;      // square-root remainder width
	localparam int LAT = 2 * DW + 5; // start to done, in cycles

	localparam logic signed [AW-1:0] ARG_ONE = {{(AW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
	localparam logic [DW-1:0] QMAX = {1'b0, {(DW-1){1'b1}}};
	localparam logic [DW-1:0] QMIN = {1'b1, {(DW-1){1'b0}}};

	typedef enum logic [1:0] {
		PC_TRACE,
		PC_M00,
		PC_M11,
		PC_M22
	} pivot_t;

	typedef struct packed {
		logic signed [DW-1:0] m00;
		logic signed [DW-1:0] m10;
		logic signed [DW-1:0] m20;
		logic signed [DW-1:0] m01;
		logic signed [DW-1:0] m11;
		logic signed [DW-1:0] m21;
		logic signed [DW-1:0] m02;
		logic signed [DW-1:0] m12;
		logic signed [DW-1:0] m22;
	} mat_t;

	typedef struct packed {
		logic signed [DW-1:0] quat_w;
		logic signed [DW-1:0] quat_x;
		logic signed [DW-1:0] quat_y;
		logic signed [DW-1:0] quat_z;
		pivot_t               pivot_case;
		logic                 bad_input;
	} quat_t;

	typedef logic [2:0][NW-1:0] num3_t;

	// Side-band through the square-root pipe
	typedef struct packed {
		logic   valid;
		pivot_t pc;
		logic   argpos;
		num3_t  num;
	} sq_side_t;

	// Side-band through the divider pipe
	typedef struct packed {
		logic          valid;
		pivot_t        pc;
		logic          argpos;
		logic [DW-1:0] piv;
	} dv_side_t;

	typedef struct packed {
		logic [2:0]          neg;
		logic [2:0]          ovf;
		logic [2:0][DW-1:0]  quo;
	} dv_res_t;

endpackage

>>> sv/rotation_matrix_to_quaternion_unit.sv
// Rotation matrix to unit quaternion (Shepperd), fully pipelined top level.
// Depends on rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe and assert_macros.svh.
//
//  Channel   Handshake            Payload
//  input     start / busy         matrix (mat_t)
//  output    done (one cycle)     result (quat_t)
//
// One transaction may start every cycle; busy stays low.
// The pipeline is three setup stages, DW square-root stages, one divider prep
// stage, DW divider stages and the output register.
// Reset clears the valid bits and side-band registers only; data in flight is dropped.
// The result is shown for one cycle with done and is never held.
`include "assert_macros.svh"

module rotation_matrix_to_quaternion_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  rmq_pkg::mat_t  matrix,
	output logic           done,
	output rmq_pkg::quat_t result
);
	import rmq_pkg::*;

	logic                 v_s1, v_s2;
	mat_t                 m_s1;
	logic signed [TW-1:0] tr_s2;
	logic signed [DW-1:0] dg_s2 [3];
	logic signed [NW-1:0] sm_s2 [6];

	sq_side_t             sq_in_s3;
	logic signed [AW-1:0] arg_s3;
	sq_side_t             sq_d;
	logic signed [AW-1:0] arg_d;
	logic [2*DW-1:0]      rad;

	sq_side_t             sq_out;
	logic [DW-1:0]        root;
	dv_side_t             dv_in;
	dv_side_t             dvo;
	dv_res_t              dro;

	quat_t                res_d;
	quat_t                result_q;
	logic                 done_q;
	logic                 piv_comp_pos;

	assign busy = 1'b0;

	// stage 1: capture the matrix
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		m_s1 <= matrix;
	end

	// stage 2: trace, diagonal and off-diagonal sums and differences
	always_ff @(posedge clk) begin
		tr_s2    <= TW'(m_s1.m00) + TW'(m_s1.m11) + TW'(m_s1.m22);
		dg_s2[0] <= m_s1.m00;
		dg_s2[1] <= m_s1.m11;
		dg_s2[2] <= m_s1.m22;
		sm_s2[0] <= NW'(m_s1.m21) - NW'(m_s1.m12);
		sm_s2[1] <= NW'(m_s1.m02) - NW'(m_s1.m20);
		sm_s2[2] <= NW'(m_s1.m10) - NW'(m_s1.m01);
		sm_s2[3] <= NW'(m_s1.m01) + NW'(m_s1.m10);
		sm_s2[4] <= NW'(m_s1.m02) + NW'(m_s1.m20);
		sm_s2[5] <= NW'(m_s1.m12) + NW'(m_s1.m21);
	end

	// stage 3: pick the pivot, its square-root argument and numerators
	always_comb begin
		logic                 t0, t1, t2, d01, d02, d12;
		logic signed [AW-1:0] trx;
		logic signed [AW-1:0] dkx;
		t0  = (tr_s2 >= TW'(dg_s2[0]));
		t1  = (tr_s2 >= TW'(dg_s2[1]));
		t2  = (tr_s2 >= TW'(dg_s2[2]));
		d01 = (dg_s2[0] >= dg_s2[1]);
		d02 = (dg_s2[0] >= dg_s2[2]);
		d12 = (dg_s2[1] >= dg_s2[2]);
		trx = AW'(tr_s2);
		sq_d = '0;
		sq_d.valid = v_s2;
		if (t0 && t1 && t2) begin
			sq_d.pc = PC_TRACE;
		end else if (d01 && d02) begin
			sq_d.pc = PC_M00;
		end else if (d12) begin
			sq_d.pc = PC_M11;
		end else begin
			sq_d.pc = PC_M22;
		end
		case (sq_d.pc)
			PC_TRACE: begin
				dkx = '0;
				sq_d.num = {sm_s2[2], sm_s2[1], sm_s2[0]};
			end
			PC_M00: begin
				dkx = AW'(dg_s2[0]);
				sq_d.num = {sm_s2[4], sm_s2[3], sm_s2[0]};
			end
			PC_M11: begin
				dkx = AW'(dg_s2[1]);
				sq_d.num = {sm_s2[5], sm_s2[3], sm_s2[1]};
			end
			default: begin
				dkx = AW'(dg_s2[2]);
				sq_d.num = {sm_s2[5], sm_s2[4], sm_s2[2]};
			end
		endcase
		if (sq_d.pc == PC_TRACE) begin
			arg_d = ARG_ONE + trx;
		end else begin
			arg_d = ARG_ONE - trx + (dkx <<< 1);
		end
		sq_d.argpos = !arg_d[AW-1] && (|arg_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_in_s3 <= '0;
		end else begin
			sq_in_s3 <= sq_d;
		end
	end

	always_ff @(posedge clk) begin
		arg_s3 <= arg_d;
	end

	// radicand: argument scaled to the root's fraction, zero when not positive
	assign rad = sq_in_s3.argpos ? ((2*DW)'(arg_s3) << (DW - 4)) : '0;

	rmq_sqrt_pipe u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_side  (sq_in_s3),
		.in_rad   (rad),
		.out_side (sq_out),
		.out_root (root)
	);

	always_comb begin
		dv_in.valid  = sq_out.valid;
		dv_in.pc     = sq_out.pc;
		dv_in.argpos = sq_out.argpos;
		dv_in.piv    = root;
	end

	rmq_div_pipe u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_side  (dv_in),
		.in_num   (sq_out.num),
		.out_side (dvo),
		.out_res  (dro)
	);

	// output stage: saturate, place components by pivot case
	always_comb begin
		logic [DW-1:0] qv [3];
		logic [2:0]    qsat;
		logic [DW-1:0] pv;
		logic          psat;
		for (int k = 0; k < 3; k++) begin
			if (dro.neg[k]) begin
				qsat[k] = dro.ovf[k] || (dro.quo[k][DW-1] && (|dro.quo[k][DW-2:0]));
				qv[k]   = qsat[k] ? QMIN : (~dro.quo[k] + DW'(1));
			end else begin
				qsat[k] = dro.ovf[k] || dro.quo[k][DW-1];
				qv[k]   = qsat[k] ? QMAX : dro.quo[k];
			end
			if (!dvo.argpos) begin
				qsat[k] = 1'b0;
				qv[k]   = '0;
			end
		end
		psat = dvo.argpos && dvo.piv[DW-1];
		pv   = !dvo.argpos ? '0 : (psat ? QMAX : dvo.piv);
		res_d.pivot_case = dvo.pc;
		res_d.bad_input  = !dvo.argpos || psat || (|qsat);
		case (dvo.pc)
			PC_TRACE: begin
				res_d.quat_w = pv;
				res_d.quat_x = qv[0];
				res_d.quat_y = qv[1];
				res_d.quat_z = qv[2];
			end
			PC_M00: begin
				res_d.quat_w = qv[0];
				res_d.quat_x = pv;
				res_d.quat_y = qv[1];
				res_d.quat_z = qv[2];
			end
			PC_M11: begin
				res_d.quat_w = qv[0];
				res_d.quat_x = qv[1];
				res_d.quat_y = pv;
				res_d.quat_z = qv[2];
			end
			default: begin
				res_d.quat_w = qv[0];
				res_d.quat_x = qv[1];
				res_d.quat_y = qv[2];
				res_d.quat_z = pv;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= dvo.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
	end

	assign done   = done_q;
	assign result = result_q;

	// pick the pivot component of the shown result and test its sign
	always_comb begin
		case (result.pivot_case)
			PC_TRACE: piv_comp_pos = (result.quat_w > 0);
			PC_M00:   piv_comp_pos = (result.quat_x > 0);
			PC_M11:   piv_comp_pos = (result.quat_y > 0);
			default:  piv_comp_pos = (result.quat_z > 0);
		endcase
	end

	// every done has a matching start and every start comes out as a done
	`ASSERT_IMPLIES(a_done_has_start, done, $past(start, LAT), "done without a matching start")
	`ASSERT_AT_CLK(a_start_gives_done, start |-> ##LAT done, "start lost in the pipeline")
	// a clean result has a strictly positive pivot component
	`ASSERT_IMPLIES(a_pivot_positive, done && !result.bad_input, piv_comp_pos, "pivot not positive")

endmodule

>>> sv/rmq_sqrt_pipe.sv
// Pipelined floor square root, one root bit per stage, DW stages.
// Depends on rmq_pkg for widths and the side-band struct.
module rmq_sqrt_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  rmq_pkg::sq_side_t in_side,
	input  logic [2*rmq_pkg::DW-1:0] in_rad,
	output rmq_pkg::sq_side_t out_side,
	output logic [rmq_pkg::DW-1:0] out_root
);
	import rmq_pkg::*;

	sq_side_t         side_s [0:DW];
	logic [RW-1:0]    rem_s  [0:DW];
	logic [DW-1:0]    root_s [0:DW];
	logic [2*DW-1:0]  rad_s  [0:DW];

	assign side_s[0] = in_side;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign rad_s[0]  = in_rad;

	for (genvar g = 0; g < DW; g++) begin : g_stage
		logic [RW-1:0] rsh;
		logic [RW-1:0] trial;
		logic          ge;

		// bring down two radicand bits and try the next root bit
		always_comb begin
			rsh   = {rem_s[g][RW-3:0], rad_s[g][2*DW-1 -: 2]};
			trial = {1'b0, root_s[g], 2'b01};
			ge    = (rsh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g+1] <= '0;
			end else begin
				side_s[g+1] <= side_s[g];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g+1]  <= ge ? (rsh - trial) : rsh;
			root_s[g+1] <= {root_s[g][DW-2:0], ge};
			rad_s[g+1]  <= rad_s[g] << 2;
		end
	end

	assign out_side = side_s[DW];
	assign out_root = root_s[DW];

endmodule

>>> sv/rmq_div_pipe.sv
// Three parallel pipelined restoring dividers sharing one divisor.
// One prep stage, then one quotient bit per stage. Depends on rmq_pkg.
module rmq_div_pipe (
	input  logic              clk,
	input  logic              arst_n,
	input  rmq_pkg::dv_side_t in_side,
	input  rmq_pkg::num3_t    in_num,
	output rmq_pkg::dv_side_t out_side,
	output rmq_pkg::dv_res_t  out_res
);
	import rmq_pkg::*;

	dv_side_t           side_s [0:DW+1];
	logic [2:0]         neg_s  [1:DW+1];
	logic [2:0]         ovf_s  [1:DW+1];
	logic [2:0][DW-1:0] rem_s  [1:DW+1];
	logic [2:0][DW-1:0] quo_s  [1:DW+1];
	logic [2:0][DW-1:0] dvd_s  [1:DW+1];
	logic [2:0][NW-1:0] mag;

	assign side_s[0] = in_side;

	// take magnitudes; a quotient of 2^DW or more shows in the top bits alone
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mag[k] = in_num[k][NW-1] ? (~in_num[k] + NW'(1)) : in_num[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s[1] <= '0;
		end else begin
			side_s[1] <= side_s[0];
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			neg_s[1][k] <= in_num[k][NW-1];
			ovf_s[1][k] <= (DW'(mag[k][NW-1:4]) >= in_side.piv);
			rem_s[1][k] <= DW'(mag[k][NW-1:4]);
			dvd_s[1][k] <= {mag[k][3:0], {(DW-4){1'b0}}};
			quo_s[1][k] <= '0;
		end
	end

	for (genvar g = 1; g <= DW; g++) begin : g_stage
		logic [2:0][DW:0] r;
		logic [2:0]       ge;

		// shift in one dividend bit per lane and trial-subtract
		always_comb begin
			for (int k = 0; k < 3; k++) begin
				r[k]  = {rem_s[g][k], dvd_s[g][k][DW-1]};
				ge[k] = (r[k] >= {1'b0, side_s[g].piv});
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				side_s[g+1] <= '0;
			end else begin
				side_s[g+1] <= side_s[g];
			end
		end

		always_ff @(posedge clk) begin
			neg_s[g+1] <= neg_s[g];
			ovf_s[g+1] <= ovf_s[g];
			for (int k = 0; k < 3; k++) begin
				rem_s[g+1][k] <= ge[k] ? DW'(r[k] - {1'b0, side_s[g].piv}) : r[k][DW-1:0];
				quo_s[g+1][k] <= {quo_s[g][k][DW-2:0], ge[k]};
				dvd_s[g+1][k] <= dvd_s[g][k] << 1;
			end
		end
	end

	assign out_side    = side_s[DW+1];
	assign out_res.neg = neg_s[DW+1];
	assign out_res.ovf = ovf_s[DW+1];
	assign out_res.quo = quo_s[DW+1];

endmodule
